[src/brbo_pkg.sv]
// ----------------------------------------------------------------------------
// brbo_pkg
// Types, op codes and sizes shared by the byte ring buffer modules.
// ----------------------------------------------------------------------------
package brbo_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 7;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_GET_N   = 3'd1,
        OP_GET_ALL = 3'd2,
        OP_COUNT   = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] request_count;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              data_valid;
        logic              last;
        logic [CNT_W-1:0]  count_value;
        logic              overflow;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic ld_byte;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic get_go;
        logic last_byte;
    } t_status;

endpackage

[src/byte_ring_buffer_overwrite_unit.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite_unit
// Byte ring buffer that overwrites the oldest byte when full.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in  (t_in_item)
//   out      output     o_out_valid / i_out_stall o_out (t_out_item)
//   cfg      input      i_cfg_we                  i_cfg_data (size in use)
//
// add, count, clear and an empty get each load one result into the output register.
// a get of k bytes then runs ST_READ and ST_LOAD for each byte: a store read, then
// a load of the output register once it frees, set by the single registered read port.
// reset is synchronous; no clearing pass, store contents start undefined.
// a stalled output holds its transfer and holds off the next accept.
// ----------------------------------------------------------------------------
module byte_ring_buffer_overwrite_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  brbo_pkg::t_in_item          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output brbo_pkg::t_out_item         o_out,
    input  logic                        i_cfg_we,
    input  logic [brbo_pkg::CNT_W-1:0]  i_cfg_data
);
    import brbo_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    brbo_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    brbo_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

[src/brbo_ram.sv]
// ----------------------------------------------------------------------------
// brbo_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module brbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/brbo_datapath.sv]
// ----------------------------------------------------------------------------
// brbo_datapath
// Pointers, fill count, overflow flag, byte store and output register.
// ----------------------------------------------------------------------------
module brbo_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  brbo_pkg::t_cmd                  i_cmd,
    output brbo_pkg::t_status               o_status,
    input  brbo_pkg::t_in_item              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output brbo_pkg::t_out_item             o_out,
    input  logic                            i_cfg_we,
    input  logic [brbo_pkg::CNT_W-1:0]      i_cfg_data
);
    import brbo_pkg::*;

    logic [CNT_W-1:0]  r_size, n_size;
    logic [ADDR_W-1:0] r_rp, n_rp;
    logic [ADDR_W-1:0] r_wp, n_wp;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_ovf, n_ovf;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic [CNT_W-1:0]  w_size;
    logic [BYTE_W-1:0] w_n;
    logic              w_is_get;
    logic              w_get_go;
    logic              w_last_byte;
    logic              w_we;
    logic [BYTE_W-1:0] w_rdata;

    function automatic logic [ADDR_W-1:0] ptr_inc(
        input logic [ADDR_W-1:0] p,
        input logic [CNT_W-1:0]  size
    );
        logic [CNT_W-1:0] nx;
        nx = CNT_W'(p) + CNT_W'(1);
        return (nx == size) ? '0 : ADDR_W'(nx);
    endfunction

    // size in use clamped to 1..DEPTH
    always_comb begin
        if (r_size == '0) begin
            w_size = CNT_W'(1);
        end else if (r_size > CNT_W'(DEPTH)) begin
            w_size = CNT_W'(DEPTH);
        end else begin
            w_size = r_size;
        end
    end

    assign w_is_get = (i_in.op == OP_GET_N) || (i_in.op == OP_GET_ALL);
    assign w_n      = (i_in.op == OP_GET_ALL) ? BYTE_W'(r_fill) : i_in.request_count;
    assign w_get_go = w_is_get && (r_fill != '0) && (w_n != '0)
                      && (w_n <= BYTE_W'(w_size));
    assign w_last_byte = (r_idx + CNT_W'(1)) == r_k;
    assign w_we = i_cmd.accept && (i_in.op == OP_ADD);

    brbo_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (i_in.value),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rp),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_size      = r_size;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cfg_we) begin
            n_size = i_cfg_data;
            n_rp   = '0;
            n_wp   = '0;
            n_fill = '0;
            n_ovf  = '0;
        end else if (i_cmd.accept) begin
            n_out.data        = '0;
            n_out.data_valid  = 1'b0;
            n_out.last        = 1'b1;
            n_out.count_value = '0;
            n_out.overflow    = r_ovf;
            case (i_in.op)
                OP_ADD: begin
                    n_wp = ptr_inc(r_wp, w_size);
                    if (r_fill >= w_size) begin
                        n_ovf = 1'b1;
                        n_rp  = ptr_inc(r_rp, w_size);
                    end else begin
                        n_ovf  = 1'b0;
                        n_fill = r_fill + CNT_W'(1);
                    end
                    n_out.overflow = n_ovf;
                    n_out_valid    = 1'b1;
                end
                OP_GET_N, OP_GET_ALL: begin
                    if (w_get_go) begin
                        // bytes follow; flag reads zero on every one of them
                        n_ovf = 1'b0;
                        n_k   = (w_n < BYTE_W'(r_fill)) ? CNT_W'(w_n) : r_fill;
                        n_idx = '0;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
                OP_COUNT: begin
                    n_out.count_value = r_fill;
                    n_out_valid       = 1'b1;
                end
                OP_CLEAR: begin
                    n_rp           = '0;
                    n_wp           = '0;
                    n_fill         = '0;
                    n_ovf          = '0;
                    n_out.overflow = 1'b0;
                    n_out_valid    = 1'b1;
                end
                default: begin
                    n_out = r_out;
                end
            endcase
        end else if (i_cmd.ld_byte) begin
            n_out.data        = w_rdata;
            n_out.data_valid  = 1'b1;
            n_out.last        = w_last_byte;
            n_out.count_value = r_k;
            n_out.overflow    = 1'b0;
            n_out_valid       = 1'b1;
            n_idx             = r_idx + CNT_W'(1);
            n_rp              = ptr_inc(r_rp, w_size);
            if (w_last_byte) begin
                // a get always drops whatever it leaves unread
                n_rp   = '0;
                n_wp   = '0;
                n_fill = '0;
                n_ovf  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= CNT_W'(DEPTH);
            r_rp        <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_k         <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_size      <= n_size;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_k         <= n_k;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_status.get_go    = w_get_go;
    assign o_status.last_byte = w_last_byte;
    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;

endmodule

[src/brbo_controller.sv]
// ----------------------------------------------------------------------------
// brbo_controller
// Sequences accepts and the read-then-load steps of a get.
// ----------------------------------------------------------------------------
module brbo_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  brbo_pkg::t_status     i_status,
    output brbo_pkg::t_cmd        o_cmd
);
    import brbo_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.get_go) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_LOAD;
            end
            ST_LOAD: begin
                // read data holds in the ram until the output register frees
                if (i_status.out_free) begin
                    o_cmd.ld_byte = 1'b1;
                    n_state       = i_status.last_byte ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[sim/byte_ring_buffer_overwrite_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite_unit_tb
// Checks the overwriting byte ring buffer against a cycle-free model of the
// ring. A short directed run covers empty, short and oversized gets, unknown
// ops and the overflow path, then random add runs followed by reads are sent
// under several ring sizes with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module byte_ring_buffer_overwrite_unit_tb;

    import brbo_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 10;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out;
    logic                i_cfg_we = 1'b0;
    logic [CNT_W-1:0]    i_cfg_data = '0;

    // ring model
    logic [BYTE_W-1:0]   ring_mem [DEPTH];
    int unsigned         rd_idx = 0;
    int unsigned         wr_idx = 0;
    int unsigned         held = 0;
    logic                ovf_flag = 1'b0;
    logic [CNT_W-1:0]    ring_cfg_size = 7'd64;

    t_in_item            op_backlog [$];
    t_out_item           due_results [$];
    int                  ops_outstanding = 0;
    bit                  in_taken = 1'b0;
    int                  idle_pct = 30;
    int                  stuck_cycles = 0;
    int                  fail_count = 0;

    byte_ring_buffer_overwrite_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned ring_span();
        if (ring_cfg_size == 0) return 1;
        if (ring_cfg_size > DEPTH) return DEPTH;
        return ring_cfg_size;
    endfunction

    function automatic void empty_ring();
        rd_idx = 0;
        wr_idx = 0;
        held = 0;
        ovf_flag = 1'b0;
    endfunction

    function automatic void post_result(logic [BYTE_W-1:0] d, logic dv, logic lst,
                                        int unsigned cnt);
        t_out_item r;
        r.data = d;
        r.data_valid = dv;
        r.last = lst;
        r.count_value = CNT_W'(cnt);
        r.overflow = ovf_flag;
        due_results.push_back(r);
    endfunction

    function automatic void apply_ring_op(t_in_item it);
        int unsigned span;
        int unsigned want;
        int unsigned k;
        span = ring_span();
        case (it.op)
            OP_ADD: begin
                ring_mem[wr_idx] = it.value;
                wr_idx = (wr_idx + 1) % span;
                if (held >= span) begin
                    // full: oldest byte is lost
                    ovf_flag = 1'b1;
                    rd_idx = (rd_idx + 1) % span;
                end else begin
                    ovf_flag = 1'b0;
                    held++;
                end
                post_result('0, 1'b0, 1'b1, 0);
            end
            OP_GET_N, OP_GET_ALL: begin
                want = (it.op == OP_GET_N) ? it.request_count : held;
                if (held == 0 || want == 0 || want > span) begin
                    post_result('0, 1'b0, 1'b1, 0);
                end else begin
                    k = (want < held) ? want : held;
                    ovf_flag = 1'b0;
                    for (int unsigned i = 0; i < k; i++) begin
                        post_result(ring_mem[rd_idx], 1'b1, (i + 1 == k), k);
                        rd_idx = (rd_idx + 1) % span;
                    end
                    // unread bytes are dropped
                    empty_ring();
                end
            end
            OP_COUNT: post_result('0, 1'b0, 1'b1, held);
            OP_CLEAR: begin
                empty_ring();
                post_result('0, 1'b0, 1'b1, 0);
            end
            default: ;
        endcase
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic queue_op(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] val,
                            input logic [BYTE_W-1:0] req);
        t_in_item it;
        it.op = op;
        it.value = val;
        it.request_count = req;
        op_backlog.push_back(it);
        ops_outstanding++;
    endtask

    task automatic write_ring_size(input logic [CNT_W-1:0] sz);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= sz;
        ring_cfg_size = sz;
        empty_ring();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (ops_outstanding != 0 || due_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // runs of adds closed by a read, mixed with single random ops
    task automatic fill_random_ops(input int unsigned target);
        int unsigned span;
        int unsigned made;
        int unsigned run_len;
        int unsigned pick;
        span = ring_span();
        made = 0;
        while (made < target) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 3) == 0)
                    run_len = $urandom_range(span, span + 2);
                else
                    run_len = $urandom_range(1, (span < 12) ? span : 12);
                for (int unsigned i = 0; i < run_len; i++)
                    queue_op(OP_ADD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    queue_op(OP_GET_ALL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else if (pick == 1)
                    queue_op(OP_COUNT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else
                    queue_op(OP_GET_N, 8'($urandom_range(0, 255)), 8'($urandom_range(1, span)));
                made += run_len + 1;
            end else begin
                pick = $urandom_range(0, 7);
                queue_op(pick[OP_W-1:0], 8'($urandom_range(0, 255)),
                         $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, span + 1)));
                if (pick <= OP_CLEAR) made++;
            end
        end
    endtask

    // driver: new transfer only once the previous one is taken
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < idle_pct);
        if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (i_rst_n && op_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_in <= op_backlog.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: both channels and the watchdog
    always @(posedge i_clk) begin
        t_out_item want;
        bit moved;
        moved = 1'b0;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            moved = 1'b1;
            if (due_results.size() == 0) begin
                flag_error($sformatf("unexpected result data=%0d cnt=%0d",
                                     o_out.data, o_out.count_value));
            end else begin
                want = due_results.pop_front();
                if (o_out.data !== want.data)
                    flag_error($sformatf("data got %0d want %0d", o_out.data, want.data));
                if (o_out.data_valid !== want.data_valid)
                    flag_error($sformatf("data_valid got %0b want %0b",
                                         o_out.data_valid, want.data_valid));
                if (o_out.last !== want.last)
                    flag_error($sformatf("last got %0b want %0b", o_out.last, want.last));
                if (o_out.count_value !== want.count_value)
                    flag_error($sformatf("count_value got %0d want %0d",
                                         o_out.count_value, want.count_value));
                if (o_out.overflow !== want.overflow)
                    flag_error($sformatf("overflow got %0b want %0b",
                                         o_out.overflow, want.overflow));
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            moved = 1'b1;
            apply_ring_op(i_in);
            in_taken = 1'b1;
            ops_outstanding--;
        end
        if (!i_rst_n || moved)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default size: empty reads, short get, unknown ops
        queue_op(OP_GET_ALL, 8'h00, 8'h00);
        queue_op(OP_GET_N, 8'h00, 8'd5);
        queue_op(OP_COUNT, 8'h00, 8'h00);
        queue_op(OP_ADD, 8'h00, 8'h00);
        queue_op(OP_ADD, 8'hFF, 8'hFF);
        queue_op(OP_ADD, 8'hA5, 8'h00);
        queue_op(OP_COUNT, 8'h00, 8'h00);
        queue_op(OP_GET_N, 8'h00, 8'd0);
        queue_op(OP_GET_N, 8'h00, 8'd65);
        queue_op(OP_GET_N, 8'h00, 8'd255);
        queue_op(OP_GET_N, 8'h00, 8'd10);
        queue_op(OP_COUNT, 8'h00, 8'h00);
        queue_op(OP_ADD, 8'h5A, 8'h00);
        queue_op(OP_CLEAR, 8'h00, 8'h00);
        queue_op(3'd5, 8'hFF, 8'hFF);
        queue_op(3'd7, 8'h00, 8'h00);
        queue_op(OP_ADD, 8'h3C, 8'h00);
        queue_op(OP_GET_ALL, 8'h00, 8'h00);
        settle();

        // size 0 acts as 1: overwrite and oversized get
        write_ring_size(7'd0);
        queue_op(OP_ADD, 8'h12, 8'h00);
        queue_op(OP_ADD, 8'h34, 8'h00);
        queue_op(OP_COUNT, 8'h00, 8'h00);
        queue_op(OP_GET_N, 8'h00, 8'd2);
        queue_op(3'd6, 8'h00, 8'h00);
        queue_op(OP_GET_N, 8'h00, 8'd1);
        settle();

        write_ring_size(7'd127);
        fill_random_ops(10);
        settle();

        write_ring_size(7'd2);
        fill_random_ops(10);
        settle();

        // no idling on either side here
        idle_pct = 0;
        write_ring_size(7'd64);
        fill_random_ops(10);
        settle();
        idle_pct = 30;

        write_ring_size(7'($urandom_range(3, 63)));
        fill_random_ops(10);
        settle();

        write_ring_size(7'd1);
        fill_random_ops(10);
        settle();

        write_ring_size(7'($urandom_range(0, 127)));
        fill_random_ops(10);
        settle();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
